>>> src/kvt_pkg.sv
`timescale 1ns / 1ps

package kvt_pkg;

  // Table size and slot index width
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Request transaction
  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] found_value;
  } rsp_t;

  // Request token walking the cell chain, gathering lookup results
  typedef struct packed {
    logic               valid;
    req_t               req;
    logic               hit;
    logic signed [31:0] rdata;
    logic               free_seen;
    logic [IDX_W-1:0]   free_idx;
  } tok_t;

  // New-entry write, broadcast to all cells from the end of the chain
  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } commit_t;

endpackage

>>> src/kvt_cell.sv
`timescale 1ns / 1ps

module kvt_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [kvt_pkg::IDX_W-1:0] cell_idx_i,
  input  kvt_pkg::tok_t             tok_i,
  input  kvt_pkg::commit_t          commit_i,
  output kvt_pkg::tok_t             tok_o
);

  logic               valid_q, valid_d;
  logic signed [31:0] key_q, key_d;
  logic signed [31:0] value_q, value_d;
  kvt_pkg::tok_t      tok_q, tok_d;
  logic               match;
  logic               commit_here;

  assign match       = tok_i.valid && valid_q && (key_q == tok_i.req.key);
  assign commit_here = commit_i.valid && (commit_i.idx == cell_idx_i);

  // Entry update: in-place update/remove on a hit, new entry on commit
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    if (match) begin
      if (tok_i.req.func == kvt_pkg::FUNC_INSERT) begin
        value_d = tok_i.req.value;
      end
      if (tok_i.req.func == kvt_pkg::FUNC_REMOVE) begin
        valid_d = 1'b0;
      end
    end
    if (commit_here) begin
      valid_d = 1'b1;
      key_d   = commit_i.key;
      value_d = commit_i.value;
    end
  end

  // Token handed on: record hit, read data and first free slot
  always_comb begin
    tok_d = tok_i;
    if (match) begin
      tok_d.hit   = 1'b1;
      tok_d.rdata = value_q;
    end
    if (!tok_i.free_seen && !valid_q) begin
      tok_d.free_seen = 1'b1;
      tok_d.free_idx  = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      tok_q.valid <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  // Entry payload, undefined until written
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign tok_o = tok_q;

endmodule

>>> src/key_value_table.sv
`timescale 1ns / 1ps

// Associative table of kvt_pkg::ENTRIES unique signed 32-bit keys with 32-bit
// values. A request (insert/update, search, remove) is taken when start is
// high and busy is low; its single result appears on rsp_o with done_o high
// for exactly one cycle and cannot be held off by the receiver. busy is
// high from acceptance until the result cycle, so a new request is taken
// only after the previous one has left the chain. The request token walks
// the chain of entry cells, one cell per cycle; a new key is written into
// the lowest free slot as the token leaves the last cell. All slots are
// empty after reset.
module key_value_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  kvt_pkg::req_t req_i,
  output logic          done_o,
  output kvt_pkg::rsp_t rsp_o
);

  localparam int unsigned N = kvt_pkg::ENTRIES;

  kvt_pkg::tok_t    chain [N+1];
  kvt_pkg::tok_t    tok_q, tok_d;
  kvt_pkg::tok_t    tail;
  kvt_pkg::commit_t commit;
  kvt_pkg::rsp_t    rsp_q, rsp_d;
  logic             busy_q, busy_d;
  logic             done_q;
  logic             accept;

  assign accept = start && !busy_q;
  assign tail   = chain[N];

  // Entry token for the head of the chain
  always_comb begin
    tok_d           = tok_q;
    tok_d.valid     = accept;
    tok_d.req       = req_i;
    tok_d.hit       = 1'b0;
    tok_d.rdata     = '0;
    tok_d.free_seen = 1'b0;
    tok_d.free_idx  = '0;
  end

  assign chain[0] = tok_q;

  // Row of entry cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    kvt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (kvt_pkg::IDX_W'(i)),
      .tok_i      (chain[i]),
      .commit_i   (commit),
      .tok_o      (chain[i+1])
    );
  end

  // New key goes to the lowest free slot when it was found nowhere
  always_comb begin
    commit.valid = tail.valid && (tail.req.func == kvt_pkg::FUNC_INSERT) &&
                   !tail.hit && tail.free_seen;
    commit.idx   = tail.free_idx;
    commit.key   = tail.req.key;
    commit.value = tail.req.value;
  end

  // Result from the token leaving the chain
  always_comb begin
    rsp_d.status      = kvt_pkg::ST_NOT_FOUND;
    rsp_d.found_value = '0;
    unique case (tail.req.func)
      kvt_pkg::FUNC_INSERT: begin
        if (tail.hit || tail.free_seen) begin
          rsp_d.status = kvt_pkg::ST_OK;
        end else begin
          rsp_d.status = kvt_pkg::ST_FULL;
        end
      end
      kvt_pkg::FUNC_SEARCH: begin
        if (tail.hit) begin
          rsp_d.status      = kvt_pkg::ST_OK;
          rsp_d.found_value = tail.rdata;
        end
      end
      kvt_pkg::FUNC_REMOVE: begin
        if (tail.hit) begin
          rsp_d.status = kvt_pkg::ST_OK;
        end
      end
      default: begin
        rsp_d.status = kvt_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // Busy from acceptance until the token leaves the chain
  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (tail.valid) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      tok_q.valid <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= tail.valid;
      tok_q  <= tok_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (tail.valid) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

>>> verif/key_value_table_test.sv
`timescale 1ns / 1ps

module key_value_table_test;

  // Code outside the defined operations; must leave the table untouched
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         KEY_POOL    = 24;
  localparam int         RANDOM_REQS = 400;

  // Table shadow plus in-order queue of predicted result transactions
  class table_scoreboard;
    logic               slot_used  [kvt_pkg::ENTRIES];
    logic signed [31:0] slot_key   [kvt_pkg::ENTRIES];
    logic signed [31:0] slot_value [kvt_pkg::ENTRIES];
    kvt_pkg::rsp_t      pending_rsp[$];
    int unsigned        errors;
    int unsigned        n_insert, n_full, n_search, n_hit, n_remove, n_unused, n_checked;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i]  = 1'b0;
        slot_key[i]   = '0;
        slot_value[i] = '0;
      end
    endfunction

    // Apply an accepted request to the shadow table and queue its result
    function void note_request(kvt_pkg::req_t r);
      int            hit;
      int            free;
      kvt_pkg::rsp_t rsp;
      hit = -1;
      free = -1;
      for (int i = 0; i < kvt_pkg::ENTRIES; i++) begin
        if (hit < 0 && slot_used[i] && slot_key[i] == r.key) hit = i;
        if (free < 0 && !slot_used[i]) free = i;
      end
      rsp.status      = kvt_pkg::ST_NOT_FOUND;
      rsp.found_value = '0;
      case (r.func)
        kvt_pkg::FUNC_INSERT: begin
          n_insert++;
          if (hit >= 0) begin
            slot_value[hit] = r.value;
            rsp.status      = kvt_pkg::ST_OK;
          end else if (free >= 0) begin
            slot_used[free]  = 1'b1;
            slot_key[free]   = r.key;
            slot_value[free] = r.value;
            rsp.status       = kvt_pkg::ST_OK;
          end else begin
            rsp.status = kvt_pkg::ST_FULL;
            n_full++;
          end
        end
        kvt_pkg::FUNC_SEARCH: begin
          n_search++;
          if (hit >= 0) begin
            rsp.status      = kvt_pkg::ST_OK;
            rsp.found_value = slot_value[hit];
            n_hit++;
          end
        end
        kvt_pkg::FUNC_REMOVE: begin
          n_remove++;
          if (hit >= 0) begin
            slot_used[hit] = 1'b0;
            rsp.status     = kvt_pkg::ST_OK;
          end
        end
        default: n_unused++;
      endcase
      pending_rsp.push_back(rsp);
    endfunction

    // Compare a result transaction with the oldest prediction
    function void check_result(kvt_pkg::rsp_t got);
      kvt_pkg::rsp_t want;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result, status %0d value %0d", $time,
                 got.status, got.found_value);
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      n_checked++;
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d", $time,
                 want.status, got.status);
        errors++;
      end
      if (got.found_value !== want.found_value) begin
        $display("%0t: found_value mismatch, expected %0d, got %0d", $time,
                 want.found_value, got.found_value);
        errors++;
      end
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           start;
  logic           busy;
  kvt_pkg::req_t  req_i;
  logic           done_o;
  kvt_pkg::rsp_t  rsp_o;

  table_scoreboard    sb = new();
  logic signed [31:0] key_pool [KEY_POOL];

  key_value_table u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Present one request and hold it until the block takes it
  task automatic send_request(input logic [1:0] func, input logic signed [31:0] key,
                              input logic signed [31:0] value);
    kvt_pkg::req_t r;
    r.func  = func;
    r.key   = key;
    r.value = value;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    sb.note_request(r);
  endtask

  task automatic idle_gap(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Result monitor: every strobe is a transaction that cannot be held off
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(rsp_o);
  end

  // Stimulus
  initial begin
    logic [1:0]         func;
    logic signed [31:0] key;
    int                 roll;
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty table, extreme keys and values, unused code, fill and overflow
    send_request(kvt_pkg::FUNC_SEARCH, 32'sd0, 32'sd7);
    send_request(kvt_pkg::FUNC_REMOVE, 32'sd5, 32'sd0);
    send_request(FUNC_UNUSED, 32'sd0, 32'sd1);
    send_request(kvt_pkg::FUNC_INSERT, 32'h8000_0000, 32'h7fff_ffff);
    send_request(kvt_pkg::FUNC_INSERT, 32'h7fff_ffff, 32'h8000_0000);
    send_request(kvt_pkg::FUNC_INSERT, 32'h7fff_ffff, 32'sd0);
    send_request(kvt_pkg::FUNC_SEARCH, 32'h8000_0000, 32'sd0);
    send_request(kvt_pkg::FUNC_REMOVE, 32'h8000_0000, 32'hffff_ffff);
    send_request(FUNC_UNUSED, 32'h7fff_ffff, 32'sd9);
    for (int i = 0; i < kvt_pkg::ENTRIES - 1; i++) begin
      send_request(kvt_pkg::FUNC_INSERT, 32'sh100 + i, $urandom);
    end
    send_request(kvt_pkg::FUNC_INSERT, 32'sh5555_aaaa, 32'sd3);
    send_request(kvt_pkg::FUNC_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
    send_request(kvt_pkg::FUNC_SEARCH, 32'h7fff_ffff, 32'sd0);

    // Small key pool so that hits, updates and full reports are common
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'sd0;
    key_pool[3] = 32'hffff_ffff;

    // Random: alternating remove-heavy and insert-heavy stretches
    for (int k = 0; k < RANDOM_REQS; k++) begin
      roll = $urandom_range(99);
      if ((k / 80) % 2 == 0) begin
        func = (roll < 30) ? kvt_pkg::FUNC_INSERT : (roll < 60) ? kvt_pkg::FUNC_SEARCH :
               (roll < 97) ? kvt_pkg::FUNC_REMOVE : FUNC_UNUSED;
      end else begin
        func = (roll < 55) ? kvt_pkg::FUNC_INSERT : (roll < 80) ? kvt_pkg::FUNC_SEARCH :
               (roll < 97) ? kvt_pkg::FUNC_REMOVE : FUNC_UNUSED;
      end
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL - 1)];
      else key = $urandom;
      send_request(func, key, $urandom);
      // no idling at all in the middle stretch
      if (!(k >= 150 && k < 250) && $urandom_range(99) < 14) idle_gap($urandom_range(1, 20));
    end

    // Drain
    start <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (kvt_pkg::ENTRIES + 4) @(posedge clk_i);

    $display("Covered %0d inserts (%0d refused as full), %0d searches (%0d hits),",
             sb.n_insert, sb.n_full, sb.n_search, sb.n_hit);
    $display("%0d removes and %0d unused codes; %0d results checked, %0d errors.",
             sb.n_remove, sb.n_unused, sb.n_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("key_value_table test passed");
    end else begin
      $display("key_value_table test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("key_value_table test failed");
    $finish;
  end

endmodule
